### rtl/core/two_button_debounce_auto_repeat_top_macros.svh
// Assertion macros for the two-button debounce block
`ifndef TWO_BUTTON_DEBOUNCE_AUTO_REPEAT_TOP_MACROS_SVH
`define TWO_BUTTON_DEBOUNCE_AUTO_REPEAT_TOP_MACROS_SVH

// Check cons in the same cycle as cond
`define TBD_ASSERT_SAME(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after cond
`define TBD_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tbd_pkg.sv
// Shared types and constants for the two-button debounce block
`timescale 1ns / 1ps

package tbd_pkg;

    localparam int unsigned CFG_INDEX_WIDTH = 3;
    localparam int unsigned CFG_DATA_WIDTH  = 16;
    localparam int unsigned DATA_WIDTH      = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PRESSED_LEVEL = 3'd0,
        REG_FIRST_DELAY   = 3'd1,
        REG_SLOW_INTERVAL = 3'd2,
        REG_SECOND_DELAY  = 3'd3,
        REG_FAST_INTERVAL = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_DELAY = 2'd1,
        PH_SLOW  = 2'd2,
        PH_FAST  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        Q_UNSTABLE = 2'd0,
        Q_RELEASED = 2'd1,
        Q_PRESSED  = 2'd2
    } qual_t;

    localparam logic [CFG_DATA_WIDTH-1:0] FIRST_DELAY_RST   = 16'd100;
    localparam logic [CFG_DATA_WIDTH-1:0] SLOW_INTERVAL_RST = 16'd20;
    localparam logic [CFG_DATA_WIDTH-1:0] SECOND_DELAY_RST  = 16'd300;
    localparam logic [CFG_DATA_WIDTH-1:0] FAST_INTERVAL_RST = 16'd10;

endpackage

### rtl/core/two_button_debounce_auto_repeat_top.sv
// Two-button debouncer with four-phase auto-repeat, one item per tick
//
// Input channel s_*: one item per tick with the raw levels of buttons A and B.
// Result channel m_*: one item per input item with a one-tick press pulse
// per button. Button A has priority; a stable release of either button, with
// neither button stably pressed, resets both repeat machines.
// Configuration: write cfg_wdata into register cfg_index while cfg_wr_en is
// high (0 pressed_level, 1 first_delay, 2 slow_interval, 3 second_delay,
// 4 fast_interval); other indexes are ignored. Write only while idle.
// The result is registered and is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while m_tready is high; the qualifier, phase
// machine and counter update of both buttons sit between the state registers
// and the result register.
// Reset: both sample pairs go to level 1, phases and counters clear,
// registers take their defaults and the result register empties.
// Stall: while m_tready is low the result holds and s_tready drops once the
// result register is full; no item is lost or repeated.
`timescale 1ns / 1ps

`include "two_button_debounce_auto_repeat_top_macros.svh"

module two_button_debounce_auto_repeat_top #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [tbd_pkg::DATA_WIDTH-1:0]         s_tdata,   // pin_a, pin_b, zero fill
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [tbd_pkg::DATA_WIDTH-1:0]         m_tdata,   // press_a, press_b, zero fill
    input  logic                                   cfg_wr_en,
    input  logic [tbd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [tbd_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata
);

    localparam int unsigned CMP_WIDTH =
        (COUNT_WIDTH > tbd_pkg::CFG_DATA_WIDTH) ? COUNT_WIDTH : tbd_pkg::CFG_DATA_WIDTH;

    typedef struct packed {
        tbd_pkg::phase_t        phase;
        logic [COUNT_WIDTH-1:0] held;
        logic [COUNT_WIDTH-1:0] rep;
    } btn_t;

    typedef struct packed {
        btn_t st;
        logic pulse;
    } step_t;

    localparam btn_t BTN_CLEAR = '{phase: tbd_pkg::PH_FIRST, held: '0, rep: '0};

    logic                                pressed_level_reg;
    logic [tbd_pkg::CFG_DATA_WIDTH-1:0]  first_delay_reg;
    logic [tbd_pkg::CFG_DATA_WIDTH-1:0]  slow_interval_reg;
    logic [tbd_pkg::CFG_DATA_WIDTH-1:0]  second_delay_reg;
    logic [tbd_pkg::CFG_DATA_WIDTH-1:0]  fast_interval_reg;

    logic [1:0] samples_a_reg, samples_a_next;
    logic [1:0] samples_b_reg, samples_b_next;
    btn_t       btn_a_reg, btn_a_next;
    btn_t       btn_b_reg, btn_b_next;

    logic                           m_tvalid_reg;
    logic [tbd_pkg::DATA_WIDTH-1:0] m_tdata_reg, m_tdata_next;

    logic           s_accept;
    logic           pin_a, pin_b;
    tbd_pkg::qual_t qual_a, qual_b;
    step_t          step_a, step_b;
    logic           press_a_next, press_b_next;

    function automatic tbd_pkg::qual_t qualify(input logic prev_cur, input logic pin,
                                               input logic level);
        tbd_pkg::qual_t q;
        if (pin != prev_cur) begin
            q = tbd_pkg::Q_UNSTABLE;
        end else if (pin == level) begin
            q = tbd_pkg::Q_PRESSED;
        end else begin
            q = tbd_pkg::Q_RELEASED;
        end
        return q;
    endfunction

    function automatic step_t advance(input btn_t b,
                                      input logic [tbd_pkg::CFG_DATA_WIDTH-1:0] first_d,
                                      input logic [tbd_pkg::CFG_DATA_WIDTH-1:0] slow_i,
                                      input logic [tbd_pkg::CFG_DATA_WIDTH-1:0] second_d,
                                      input logic [tbd_pkg::CFG_DATA_WIDTH-1:0] fast_i);
        step_t                  r;
        logic [COUNT_WIDTH-1:0] held_inc;
        logic [COUNT_WIDTH-1:0] rep_inc;
        r        = '{st: b, pulse: 1'b0};
        held_inc = b.held + COUNT_WIDTH'(1);
        rep_inc  = b.rep + COUNT_WIDTH'(1);
        case (b.phase)
            tbd_pkg::PH_FIRST: begin
                r.pulse    = 1'b1;
                r.st.phase = tbd_pkg::PH_DELAY;
            end
            tbd_pkg::PH_DELAY: begin
                r.st.held = held_inc;
                if (CMP_WIDTH'(held_inc) >= CMP_WIDTH'(first_d)) begin
                    r.pulse    = 1'b1;
                    r.st.phase = tbd_pkg::PH_SLOW;
                end
            end
            tbd_pkg::PH_SLOW: begin
                r.st.held = held_inc;
                r.st.rep  = rep_inc;
                if (CMP_WIDTH'(rep_inc) == CMP_WIDTH'(slow_i)) begin
                    r.pulse  = 1'b1;
                    r.st.rep = '0;
                end
                if (CMP_WIDTH'(held_inc) >= CMP_WIDTH'(second_d)) begin
                    r.pulse    = 1'b1;
                    r.st.phase = tbd_pkg::PH_FAST;
                end
            end
            tbd_pkg::PH_FAST: begin
                r.st.held = held_inc;
                if (CMP_WIDTH'(held_inc) >= CMP_WIDTH'(fast_i)) begin
                    r.pulse   = 1'b1;
                    r.st.held = '0;
                end
            end
            default: begin
                r = '{st: b, pulse: 1'b0};
            end
        endcase
        return r;
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign pin_a    = s_tdata[0];
    assign pin_b    = s_tdata[1];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        samples_a_next = {samples_a_reg[0], pin_a};
        samples_b_next = {samples_b_reg[0], pin_b};
        qual_a = qualify(samples_a_reg[0], pin_a, pressed_level_reg);
        qual_b = qualify(samples_b_reg[0], pin_b, pressed_level_reg);
        step_a = advance(btn_a_reg, first_delay_reg, slow_interval_reg,
                         second_delay_reg, fast_interval_reg);
        step_b = advance(btn_b_reg, first_delay_reg, slow_interval_reg,
                         second_delay_reg, fast_interval_reg);
        btn_a_next   = btn_a_reg;
        btn_b_next   = btn_b_reg;
        press_a_next = 1'b0;
        press_b_next = 1'b0;
        if (qual_a == tbd_pkg::Q_PRESSED) begin
            btn_a_next   = step_a.st;
            btn_b_next   = BTN_CLEAR;
            press_a_next = step_a.pulse;
        end else if (qual_b == tbd_pkg::Q_PRESSED) begin
            btn_a_next   = BTN_CLEAR;
            btn_b_next   = step_b.st;
            press_b_next = step_b.pulse;
        end else if (qual_a == tbd_pkg::Q_RELEASED || qual_b == tbd_pkg::Q_RELEASED) begin
            btn_a_next = BTN_CLEAR;
            btn_b_next = BTN_CLEAR;
        end
        m_tdata_next = {{(tbd_pkg::DATA_WIDTH-2){1'b0}}, press_b_next, press_a_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_level_reg <= 1'b0;
            first_delay_reg   <= tbd_pkg::FIRST_DELAY_RST;
            slow_interval_reg <= tbd_pkg::SLOW_INTERVAL_RST;
            second_delay_reg  <= tbd_pkg::SECOND_DELAY_RST;
            fast_interval_reg <= tbd_pkg::FAST_INTERVAL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tbd_pkg::REG_PRESSED_LEVEL: pressed_level_reg <= cfg_wdata[0];
                tbd_pkg::REG_FIRST_DELAY:   first_delay_reg   <= cfg_wdata;
                tbd_pkg::REG_SLOW_INTERVAL: slow_interval_reg <= cfg_wdata;
                tbd_pkg::REG_SECOND_DELAY:  second_delay_reg  <= cfg_wdata;
                tbd_pkg::REG_FAST_INTERVAL: fast_interval_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_a_reg <= 2'b11;
            samples_b_reg <= 2'b11;
            btn_a_reg     <= BTN_CLEAR;
            btn_b_reg     <= BTN_CLEAR;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                samples_a_reg <= samples_a_next;
                samples_b_reg <= samples_b_next;
                btn_a_reg     <= btn_a_next;
                btn_b_reg     <= btn_b_next;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    `TBD_ASSERT_SAME(a_one_press, aclk, aresetn, m_tvalid_reg,
        !(m_tdata_reg[0] && m_tdata_reg[1]), "both buttons pulsed in one item")
    `TBD_ASSERT_SAME(a_one_machine, aclk, aresetn, 1'b1,
        btn_a_reg.phase == tbd_pkg::PH_FIRST || btn_b_reg.phase == tbd_pkg::PH_FIRST,
        "both repeat machines active")
    `TBD_ASSERT_NEXT(a_accept_result, aclk, aresetn, s_accept, m_tvalid_reg,
        "accepted item gave no result")
    `TBD_ASSERT_NEXT(a_first_pulse, aclk, aresetn,
        s_accept && btn_a_reg.phase == tbd_pkg::PH_FIRST && qual_a == tbd_pkg::Q_PRESSED,
        m_tdata_reg[0] && btn_a_reg.phase == tbd_pkg::PH_DELAY,
        "first press of A gave no pulse")

endmodule
